[src/rau_pkg.sv]
// Package for the rational arithmetic unit: opcodes, status codes and word types.
// Depends on nothing; used by the channel interface and the top level.
`timescale 1ns / 1ps
package rau_pkg;

	localparam int OPERAND_WIDTH = 32;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] a_num;
		logic [30:0]        a_den;
		logic signed [31:0] b_num;
		logic [30:0]        b_den;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic               equal_flag;
		logic [1:0]         status;
	} out_word_t;

endpackage

[src/rau_chan_if.sv]
// Valid/ready channel that carries one word of a given type.
// Depends on rau_pkg for the word types used as its parameter.
`timescale 1ns / 1ps
interface rau_chan_if #(parameter type word_t = rau_pkg::in_word_t);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/rational_arithmetic_unit.sv]
// Rational arithmetic unit: add, subtract, multiply, divide and compare of fractions.
// Depends on rau_pkg and rau_chan_if.
`timescale 1ns / 1ps
// The unit takes one word at a time and is not ready until its result has been taken.
// The cross products are formed one after another on a single shared 33 by 33 bit
// multiplier. A compare goes from the third multiply state straight to the output.
// An arithmetic word with a zero numerator answers from the sign state. Any other
// arithmetic word goes on to a binary gcd on one shared 64-bit subtractor (one step a
// cycle, with common factors of two removed first) and two restoring divisions by the gcd.
// Unused opcodes, and arithmetic words with a zero denominator or division by zero,
// answer in the cycle after the word is taken.
module rational_arithmetic_unit (
	input logic clk,
	input logic arst_n,
	rau_chan_if.sink   in,
	rau_chan_if.source out
);
	import rau_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_MUL1  = 11'b00000000010,
		S_MUL2  = 11'b00000000100,
		S_MUL3  = 11'b00000001000,
		S_MUL4  = 11'b00000010000,
		S_SIGN  = 11'b00000100000,
		S_TWO   = 11'b00001000000,
		S_GCD   = 11'b00010000000,
		S_DIV   = 11'b00100000000,
		S_CHECK = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	localparam logic [63:0] LIM = 64'(1) << (OPERAND_WIDTH - 1);

	state_t state_q;
	in_word_t w_q;
	out_word_t res_q;
	logic signed [63:0] prod_q, pn_q, pd_q;
	logic [63:0] mn_q, md_q, u_q, v_q, g_q, rem_q, quo_q;
	logic [5:0] k_q, cnt_q;
	logic neg_q, div2_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic [63:0] big, sml, dif;
	logic [64:0] r2;
	logic ge;
	logic [63:0] mn_w, md_w;

	always_comb begin
		mul_a = 33'(w_q.a_num);
		mul_b = {2'b00, w_q.b_den};
		case (state_q)
			S_MUL1: begin
				mul_a = 33'(w_q.a_num);
				mul_b = (w_q.opcode == OP_MUL) ? 33'(w_q.b_num) : {2'b00, w_q.b_den};
			end
			S_MUL2: begin
				mul_a = {2'b00, w_q.a_den};
				mul_b = (w_q.opcode == OP_MUL) ? {2'b00, w_q.b_den} : 33'(w_q.b_num);
			end
			default: begin
				mul_a = {2'b00, w_q.a_den};
				mul_b = {2'b00, w_q.b_den};
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		big = (u_q >= v_q) ? u_q : v_q;
		sml = (u_q >= v_q) ? v_q : u_q;
		dif = big - sml;
		r2  = {rem_q, quo_q[63]};
		ge  = r2 >= {1'b0, g_q};
		mn_w = pn_q[63] ? 64'(-pn_q) : 64'(pn_q);
		md_w = pd_q[63] ? 64'(-pd_q) : 64'(pd_q);
	end

	assign in.ready  = (state_q == S_IDLE);
	assign out.valid = (state_q == S_OUT);
	assign out.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in.valid) begin
						w_q <= in.data;
						if (in.data.opcode > OP_CMP) begin
							res_q <= '{res_num: '0, res_den: 31'd1, equal_flag: 1'b0,
								status: ST_OK};
							state_q <= S_OUT;
						end else if (in.data.opcode != OP_CMP && (in.data.a_den == '0
							|| in.data.b_den == '0
							|| (in.data.opcode == OP_DIV && in.data.b_num == '0))) begin
							res_q <= '{res_num: '0, res_den: 31'd1, equal_flag: 1'b0,
								status: ST_DIVZ};
							state_q <= S_OUT;
						end else begin
							res_q <= '{res_num: '0, res_den: 31'd1, equal_flag: 1'b0,
								status: ST_OK};
							state_q <= S_MUL1;
						end
					end
				end
				S_MUL1: begin
					prod_q <= mul_p[63:0];
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					pn_q <= prod_q;
					prod_q <= mul_p[63:0];
					state_q <= S_MUL3;
				end
				S_MUL3: begin
					prod_q <= mul_p[63:0];
					state_q <= (w_q.opcode == OP_CMP) ? S_OUT : S_MUL4;
					case (w_q.opcode)
						OP_ADD: pn_q <= pn_q + prod_q;
						OP_SUB: pn_q <= pn_q - prod_q;
						OP_CMP: res_q.equal_flag <= (pn_q == prod_q);
						default: pd_q <= prod_q;
					endcase
				end
				S_MUL4: begin
					if (w_q.opcode == OP_ADD || w_q.opcode == OP_SUB) begin
						pd_q <= prod_q;
					end
					state_q <= S_SIGN;
				end
				S_SIGN: begin
					neg_q <= pn_q[63] ^ pd_q[63];
					mn_q <= mn_w;
					md_q <= md_w;
					u_q <= mn_w;
					v_q <= md_w;
					k_q <= '0;
					state_q <= (mn_w == '0) ? S_OUT : S_TWO;
				end
				S_TWO: begin
					if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + 6'd1;
					end else begin
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					if (u_q == '0) begin
						g_q <= v_q << k_q;
						rem_q <= '0;
						quo_q <= mn_q;
						cnt_q <= '0;
						div2_q <= 1'b0;
						state_q <= S_DIV;
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (u_q >= v_q) begin
						u_q <= dif >> 1;
					end else begin
						v_q <= dif >> 1;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63 && !div2_q) begin
						mn_q <= {quo_q[62:0], ge};
						rem_q <= '0;
						quo_q <= md_q;
						div2_q <= 1'b1;
					end else begin
						rem_q <= ge ? 64'(r2 - {1'b0, g_q}) : r2[63:0];
						quo_q <= {quo_q[62:0], ge};
						if (cnt_q == 6'd63) begin
							md_q <= {quo_q[62:0], ge};
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (md_q > LIM - 64'd1 || (neg_q ? mn_q > LIM : mn_q > LIM - 64'd1)) begin
						res_q.status <= ST_OVF;
					end else begin
						res_q.res_num <= neg_q ? -mn_q[31:0] : mn_q[31:0];
						res_q.res_den <= md_q[30:0];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[dv/testbench.sv]
// Testbench for the rational arithmetic unit: directed and random fractions, checked word by word.
// Depends on rau_pkg and rau_chan_if from the source folder.
`timescale 1ns / 1ps
module testbench;
	import rau_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	rau_chan_if #(.word_t(in_word_t))  in_ch();
	rau_chan_if #(.word_t(out_word_t)) out_ch();

	rational_arithmetic_unit u_dut (.clk(clk), .arst_n(arst_n), .in(in_ch), .out(out_ch));

	in_word_t  pending_words[$];
	out_word_t expected_results[$];
	int        mismatches = 0;
	int        src_idle_pct = 33;
	int        snk_idle_pct = 85;
	int        hold_off = 0;
	int        quiet_cycles = 0;

	function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic out_word_t compute_fraction(in_word_t w);
		out_word_t r;
		longint an, ad, bn, bd, pn, pd;
		longint unsigned mn, md, g, lim;
		bit neg;
		r.res_num = '0;
		r.res_den = 31'd1;
		r.equal_flag = 1'b0;
		r.status = ST_OK;
		an = longint'(w.a_num);
		ad = longint'({1'b0, w.a_den});
		bn = longint'(w.b_num);
		bd = longint'({1'b0, w.b_den});
		if (w.opcode == OP_CMP) begin
			r.equal_flag = (an * bd == bn * ad);
			return r;
		end
		if (w.opcode > OP_CMP) return r;
		if (ad == 0 || bd == 0 || (w.opcode == OP_DIV && bn == 0)) begin
			r.status = ST_DIVZ;
			return r;
		end
		case (w.opcode)
			OP_ADD: begin pn = an * bd + bn * ad; pd = ad * bd; end
			OP_SUB: begin pn = an * bd - bn * ad; pd = ad * bd; end
			OP_MUL: begin pn = an * bn; pd = ad * bd; end
			default: begin pn = an * bd; pd = ad * bn; end
		endcase
		neg = (pn < 0) != (pd < 0);
		mn = (pn < 0) ? -pn : pn;
		md = (pd < 0) ? -pd : pd;
		if (mn == 0) begin
			neg = 1'b0;
			md = 1;
		end else begin
			g = gcd64(mn, md);
			mn = mn / g;
			md = md / g;
		end
		lim = 64'd1 << (OPERAND_WIDTH - 1);
		if (md > lim - 1 || (neg ? mn > lim : mn > lim - 1)) begin
			r.status = ST_OVF;
			return r;
		end
		r.res_num = 32'(neg ? -mn : mn);
		r.res_den = 31'(md);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch in %s: got %0d, expected %0d", what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid && in_ch.ready)
				expected_results.push_back(compute_fraction(in_ch.data));
			if (pending_words.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				in_ch.valid <= 1'b1;
				in_ch.data <= pending_words.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result words", 1, 0);
				end else begin
					out_word_t e;
					e = expected_results.pop_front();
					if (out_ch.data.res_num !== e.res_num)
						report_mismatch("res_num", out_ch.data.res_num, e.res_num);
					if (out_ch.data.res_den !== e.res_den)
						report_mismatch("res_den", out_ch.data.res_den, e.res_den);
					if (out_ch.data.equal_flag !== e.equal_flag)
						report_mismatch("equal_flag", out_ch.data.equal_flag, e.equal_flag);
					if (out_ch.data.status !== e.status)
						report_mismatch("status", out_ch.data.status, e.status);
				end
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic signed [31:0] random_num();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(20);
			2: return -$urandom_range(20);
			3: return 32'sh7fffffff - $urandom_range(3);
			4: return 32'sh80000000 + $urandom_range(3);
			default: return $urandom_range(2000) - 1000;
		endcase
	endfunction

	function automatic logic [30:0] random_den();
		case ($urandom_range(4))
			0: return 31'($urandom);
			1: return 31'($urandom_range(30));
			2: return 31'(31'h7fffffff - $urandom_range(3));
			default: return 31'($urandom_range(1000, 1));
		endcase
	endfunction

	task automatic queue_word(logic [2:0] op, logic signed [31:0] an, logic [30:0] ad,
			logic signed [31:0] bn, logic [30:0] bd);
		in_word_t w;
		w.opcode = op;
		w.a_num = an;
		w.a_den = ad;
		w.b_num = bn;
		w.b_den = bd;
		pending_words.push_back(w);
	endtask

	task automatic wait_drained();
		while (pending_words.size() > 0 || in_ch.valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		in_word_t w;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		for (int op = 0; op < 8; op++) begin
			queue_word(3'(op), 32'sd3, 31'd4, -32'sd5, 31'd6);
		end
		queue_word(OP_ADD, 32'sh7fffffff, 31'd1, 32'sh7fffffff, 31'd1);
		queue_word(OP_SUB, 32'sh80000000, 31'd1, 32'sd0, 31'd1);
		queue_word(OP_SUB, 32'sd0, 31'd1, 32'sh80000000, 31'd1);
		queue_word(OP_MUL, 32'sh80000000, 31'd1, -32'sd1, 31'd1);
		queue_word(OP_MUL, 32'sh80000000, 31'h7fffffff, 32'sh7fffffff, 31'h7fffffff);
		queue_word(OP_DIV, 32'sd7, 31'd3, 32'sd0, 31'd5);
		queue_word(OP_DIV, -32'sd7, 31'd3, -32'sd14, 31'd9);
		queue_word(OP_ADD, 32'sd1, 31'd0, 32'sd1, 31'd1);
		queue_word(OP_MUL, 32'sd1, 31'd2, 32'sd1, 31'd0);
		queue_word(OP_CMP, 32'sd2, 31'd4, 32'sd1, 31'd2);
		queue_word(OP_CMP, 32'sd1, 31'd0, 32'sd2, 31'd0);
		queue_word(OP_SUB, 32'sd5, 31'd7, 32'sd5, 31'd7);
		queue_word(OP_ADD, 32'sh80000000, 31'h7fffffff, 32'sh80000000, 31'h7fffffff);
		queue_word(OP_DIV, 32'sh7fffffff, 31'd1, 32'sd1, 31'h7fffffff);
		wait_drained();
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 85 : 0;
			snk_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 33 : 0;
			if (phase == 2) hold_off = 3000;
			for (int i = 0; i < 135; i++) begin
				w.opcode = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
					: 3'($urandom_range(4));
				w.a_num = random_num();
				w.b_num = random_num();
				w.a_den = random_den();
				w.b_den = random_den();
				if (w.opcode == OP_CMP && $urandom_range(1)) begin
					w.b_num = w.a_num;
					w.b_den = w.a_den;
				end
				pending_words.push_back(w);
			end
			wait_drained();
		end
		repeat (400) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

[rational_arithmetic_unit.f]
src/rau_pkg.sv
src/rau_chan_if.sv
src/rational_arithmetic_unit.sv
dv/testbench.sv
